>>> rtl/core/rvm_pkg.sv
`timescale 1ns / 1ps

package rvm_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD_LEFT  = 2'd0,
        MODE_LOAD_RIGHT = 2'd1,
        MODE_SET_POS    = 2'd2,
        MODE_MIX        = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        FMT_U8_U8   = 2'd0,
        FMT_S16_U8  = 2'd1,
        FMT_U8_S16  = 2'd2,
        FMT_S16_S16 = 2'd3
    } t_fmt;

    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_ADDR_W  = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_STEREO = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;

    localparam logic [31:0] STEP_RESET = 32'h0001_0000;

endpackage

>>> rtl/core/rvm_channel.sv
`timescale 1ns / 1ps

module rvm_channel (
    input  rvm_pkg::t_fmt i_fmt,
    input  logic [15:0]   i_qa,
    input  logic [15:0]   i_qb,
    input  logic [15:0]   i_dest,
    output logic [15:0]   o_mixed
);

    logic signed [17:0] w_add;
    logic signed [17:0] w_dest;
    logic signed [17:0] w_sum;
    logic               w_out8;

    always_comb begin
        w_out8 = i_fmt inside {rvm_pkg::FMT_U8_U8, rvm_pkg::FMT_S16_U8};
        case (i_fmt)
            rvm_pkg::FMT_U8_U8, rvm_pkg::FMT_S16_U8: begin
                w_add = {{10{i_qa[7]}}, i_qa[7:0]};
            end
            rvm_pkg::FMT_U8_S16: begin
                w_add = {{2{i_qa[15]}}, i_qa};
            end
            rvm_pkg::FMT_S16_S16: begin
                w_add = $signed({{10{i_qa[15]}}, i_qa[15:8]})
                      + $signed({{2{i_qb[15]}}, i_qb})
                      + 18'sd128;
            end
            default: begin
                w_add = '0;
            end
        endcase
        if (w_out8) begin
            w_dest = {10'd0, i_dest[7:0]};
        end else begin
            w_dest = {{2{i_dest[15]}}, i_dest};
        end
        w_sum = w_dest + w_add;
        if (w_out8) begin
            if (w_sum < 18'sd0) begin
                o_mixed = 16'h0000;
            end else if (w_sum > 18'sd255) begin
                o_mixed = 16'h00FF;
            end else begin
                o_mixed = {8'h00, w_sum[7:0]};
            end
        end else begin
            if (w_sum < -18'sd32768) begin
                o_mixed = 16'h8000;
            end else if (w_sum > 18'sd32767) begin
                o_mixed = 16'h7FFF;
            end else begin
                o_mixed = w_sum[15:0];
            end
        end
    end

endmodule

>>> rtl/core/resampling_voice_mixer_core.sv
`timescale 1ns / 1ps

// Resampling voice mixer. One item is taken every cycle unless the output
// stalls, and a mix item gives its result from the output register behind
// the table-read stage; load and set-position items give none. Each volume
// table is read at two addresses by its registered read port in the accept
// cycle, and the add and clamp follow in the next stage. The tables come
// up unwritten and are not cleared after reset, so load every entry that a
// mix will touch. Registers sit at byte addresses 0 (format), 4 (stereo)
// and 8 (step rate) and may be written only while the block is idle.
module resampling_voice_mixer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_mode,
    input  logic [rvm_pkg::TABLE_ADDR_W-1:0]    i_table_index,
    input  logic signed [15:0]                  i_table_word,
    input  logic [31:0]                         i_position_value,
    input  logic [15:0]                         i_source_sample,
    input  logic [15:0]                         i_dest_left,
    input  logic [15:0]                         i_dest_right,
    input  logic                                i_last_frame,

    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [15:0]                         o_mixed_left,
    output logic [15:0]                         o_mixed_right,
    output logic [15:0]                         o_next_source_index,
    output logic [31:0]                         o_position_out,
    output logic                                o_call_done,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [15:0] r_left_mem  [rvm_pkg::TABLE_ENTRIES];
    logic [15:0] r_right_mem [rvm_pkg::TABLE_ENTRIES];

    rvm_pkg::t_fmt r_fmt;
    logic          r_stereo;
    logic [31:0]   r_step;
    logic [31:0]   r_pos;
    logic [31:0]   n_pos;

    logic          r_s1_valid;
    logic [15:0]   r_s1_dest_l;
    logic [15:0]   r_s1_dest_r;
    logic [31:0]   r_s1_pos;
    logic          r_s1_last;
    logic [15:0]   r_qa_l;
    logic [15:0]   r_qb_l;
    logic [15:0]   r_qa_r;
    logic [15:0]   r_qb_r;

    logic          r_o_valid;
    logic [15:0]   r_o_left;
    logic [15:0]   r_o_right;
    logic [31:0]   r_o_pos;
    logic          r_o_last;

    rvm_pkg::t_mode w_mode;
    logic           w_in_acc;
    logic           w_mix_acc;
    logic           w_s1_move;
    logic           w_cfg_wr;
    logic [rvm_pkg::TABLE_ADDR_W-1:0] w_addr_a;
    logic [rvm_pkg::TABLE_ADDR_W-1:0] w_addr_b;
    logic [15:0]    w_mix_l;
    logic [15:0]    w_mix_r;

    assign w_mode    = rvm_pkg::t_mode'(i_mode);
    assign w_s1_move = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready   = !r_s1_valid || w_s1_move;
    assign w_in_acc  = i_valid && o_ready;
    assign w_mix_acc = w_in_acc && (w_mode == rvm_pkg::MODE_MIX);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign n_pos     = r_pos + r_step;

    // byte code of the sample's high half, offset to unsigned
    assign w_addr_b = {~i_source_sample[15], i_source_sample[14:8]};
    assign w_addr_a = (r_fmt == rvm_pkg::FMT_S16_U8) ? w_addr_b : i_source_sample[7:0];

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_mode == rvm_pkg::MODE_LOAD_LEFT)) begin
            r_left_mem[i_table_index] <= $unsigned(i_table_word);
        end
        if (w_mix_acc) begin
            r_qa_l <= r_left_mem[w_addr_a];
            r_qb_l <= r_left_mem[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_mode == rvm_pkg::MODE_LOAD_RIGHT)) begin
            r_right_mem[i_table_index] <= $unsigned(i_table_word);
        end
        if (w_mix_acc) begin
            r_qa_r <= r_right_mem[w_addr_a];
            r_qb_r <= r_right_mem[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= rvm_pkg::FMT_U8_U8;
            r_stereo   <= 1'b0;
            r_step     <= rvm_pkg::STEP_RESET;
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    rvm_pkg::REG_FORMAT: r_fmt    <= rvm_pkg::t_fmt'(pwdata[1:0]);
                    rvm_pkg::REG_STEREO: r_stereo <= pwdata[0];
                    rvm_pkg::REG_STEP:   r_step   <= pwdata;
                    default: begin
                    end
                endcase
            end
            if (w_in_acc && (w_mode == rvm_pkg::MODE_SET_POS)) begin
                r_pos <= i_position_value;
            end else if (w_mix_acc) begin
                r_pos <= n_pos;
            end
            if (w_mix_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mix_acc) begin
            r_s1_dest_l <= i_dest_left;
            r_s1_dest_r <= i_dest_right;
            r_s1_pos    <= n_pos;
            r_s1_last   <= i_last_frame;
        end
        if (w_s1_move) begin
            r_o_left  <= w_mix_l;
            r_o_right <= r_stereo ? w_mix_r : r_s1_dest_r;
            r_o_pos   <= r_s1_pos;
            r_o_last  <= r_s1_last;
        end
    end

    rvm_channel u_left (
        .i_fmt   (r_fmt),
        .i_qa    (r_qa_l),
        .i_qb    (r_qb_l),
        .i_dest  (r_s1_dest_l),
        .o_mixed (w_mix_l)
    );

    rvm_channel u_right (
        .i_fmt   (r_fmt),
        .i_qa    (r_qa_r),
        .i_qb    (r_qb_r),
        .i_dest  (r_s1_dest_r),
        .o_mixed (w_mix_r)
    );

    always_comb begin
        case (paddr[3:2])
            rvm_pkg::REG_FORMAT: prdata = {30'd0, r_fmt};
            rvm_pkg::REG_STEREO: prdata = {31'd0, r_stereo};
            rvm_pkg::REG_STEP:   prdata = r_step;
            default:             prdata = '0;
        endcase
    end

    assign pready              = 1'b1;
    assign o_valid             = r_o_valid;
    assign o_mixed_left        = r_o_left;
    assign o_mixed_right       = r_o_right;
    assign o_next_source_index = r_o_pos[31:16];
    assign o_position_out      = r_o_pos;
    assign o_call_done         = r_o_last;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_mix_acc) |=> !r_s1_valid)
        else $error("non-mix item entered the mix stage");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mix_acc |=> (r_pos == $past(r_pos) + $past(r_step)))
        else $error("position did not advance by the step rate");

    a_stage_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mix_acc |=> (r_s1_pos == r_pos))
        else $error("mix stage position differs from the held position");

    a_out8_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_move && (r_fmt == rvm_pkg::FMT_U8_U8 || r_fmt == rvm_pkg::FMT_S16_U8))
        |=> (o_mixed_left[15:8] == 8'h00))
        else $error("8-bit output has a nonzero upper byte");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] index;
        logic [31:0] position;
        logic        done;
    } t_mixed_frame;

    logic                             i_clk;
    logic                             i_rst_n          = 1'b0;
    logic                             i_valid          = 1'b0;
    logic                             o_ready;
    logic [1:0]                       i_mode           = '0;
    logic [rvm_pkg::TABLE_ADDR_W-1:0] i_table_index    = '0;
    logic signed [15:0]               i_table_word     = '0;
    logic [31:0]                      i_position_value = '0;
    logic [15:0]                      i_source_sample  = '0;
    logic [15:0]                      i_dest_left      = '0;
    logic [15:0]                      i_dest_right     = '0;
    logic                             i_last_frame     = 1'b0;
    logic                             o_valid;
    logic                             i_ready          = 1'b0;
    logic [15:0]                      o_mixed_left;
    logic [15:0]                      o_mixed_right;
    logic [15:0]                      o_next_source_index;
    logic [31:0]                      o_position_out;
    logic                             o_call_done;
    logic                             psel             = 1'b0;
    logic                             penable          = 1'b0;
    logic                             pwrite           = 1'b0;
    logic [3:0]                       paddr            = '0;
    logic [31:0]                      pwdata           = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    rvm_pkg::t_fmt cfg_format    = rvm_pkg::FMT_U8_U8;
    logic          cfg_stereo    = 1'b0;
    logic [31:0]   cfg_step      = rvm_pkg::STEP_RESET;
    logic [31:0]   pred_position = '0;
    logic [15:0]   vol_left [rvm_pkg::TABLE_ENTRIES];
    logic [15:0]   vol_right [rvm_pkg::TABLE_ENTRIES];
    t_mixed_frame  expected_frames [$];
    t_mixed_frame  want;
    int            n_errors      = 0;
    int            hold_req      = 0;
    int            hold_seen     = 0;
    int            hold_left     = 0;
    bit            steady        = 1'b0;

    resampling_voice_mixer_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_table_index      (i_table_index),
        .i_table_word       (i_table_word),
        .i_position_value   (i_position_value),
        .i_source_sample    (i_source_sample),
        .i_dest_left        (i_dest_left),
        .i_dest_right       (i_dest_right),
        .i_last_frame       (i_last_frame),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_mixed_left       (o_mixed_left),
        .o_mixed_right      (o_mixed_right),
        .o_next_source_index(o_next_source_index),
        .o_position_out     (o_position_out),
        .o_call_done        (o_call_done),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [15:0] vol_entry(input bit right_ch, input logic [7:0] a);
        return right_ch ? vol_right[a] : vol_left[a];
    endfunction

    function automatic int volume_addend(input bit right_ch, input logic [15:0] raw);
        logic [15:0] lo_e;
        logic [15:0] hi_e;
        logic [15:0] u;
        case (cfg_format)
            rvm_pkg::FMT_U8_U8: begin
                lo_e = vol_entry(right_ch, raw[7:0]);
                return int'($signed(lo_e[7:0]));
            end
            rvm_pkg::FMT_S16_U8: begin
                lo_e = vol_entry(right_ch, raw[15:8] ^ 8'h80);
                return int'($signed(lo_e[7:0]));
            end
            rvm_pkg::FMT_U8_S16: begin
                lo_e = vol_entry(right_ch, raw[7:0]);
                return int'($signed(lo_e));
            end
            default: begin
                u    = raw ^ 16'h8000;
                lo_e = vol_entry(right_ch, u[7:0]);
                hi_e = vol_entry(right_ch, u[15:8]);
                return int'($signed(lo_e[15:8])) + int'($signed(hi_e)) + 128;
            end
        endcase
    endfunction

    function automatic logic [15:0] mix_channel(input bit right_ch, input logic [15:0] raw,
                                                input logic [15:0] dest);
        int sum;
        if (cfg_format == rvm_pkg::FMT_U8_U8 || cfg_format == rvm_pkg::FMT_S16_U8) begin
            sum = int'(dest[7:0]) + volume_addend(right_ch, raw);
            if (sum < 0) sum = 0;
            else if (sum > 255) sum = 255;
        end else begin
            sum = int'($signed(dest)) + volume_addend(right_ch, raw);
            if (sum < -32768) sum = -32768;
            else if (sum > 32767) sum = 32767;
        end
        return sum[15:0];
    endfunction

    task automatic predict_item(input rvm_pkg::t_mode m, input logic [7:0] idx,
                                input logic [15:0] word, input logic [31:0] pos,
                                input logic [15:0] smp, input logic [15:0] dl,
                                input logic [15:0] dr, input bit last);
        t_mixed_frame f;
        case (m)
            rvm_pkg::MODE_LOAD_LEFT:  vol_left[idx] = word;
            rvm_pkg::MODE_LOAD_RIGHT: vol_right[idx] = word;
            rvm_pkg::MODE_SET_POS:    pred_position = pos;
            default: begin
                f.left        = mix_channel(1'b0, smp, dl);
                f.right       = cfg_stereo ? mix_channel(1'b1, smp, dr) : dr;
                pred_position = pred_position + cfg_step;
                f.index       = pred_position[31:16];
                f.position    = pred_position;
                f.done        = last;
                expected_frames.push_back(f);
            end
        endcase
    endtask

    task automatic send_item(input rvm_pkg::t_mode m, input logic [7:0] idx,
                             input logic [15:0] word, input logic [31:0] pos,
                             input logic [15:0] smp, input logic [15:0] dl,
                             input logic [15:0] dr, input bit last);
        while (!steady && $urandom_range(99) < 11) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_mode           = m;
        i_table_index    = idx;
        i_table_word     = word;
        i_position_value = pos;
        i_source_sample  = smp;
        i_dest_left      = dl;
        i_dest_right     = dr;
        i_last_frame     = last;
        do @(posedge i_clk); while (!o_ready);
        predict_item(m, idx, word, pos, smp, dl, dr, last);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic load_entry(input bit right_ch, input logic [7:0] idx, input logic [15:0] word);
        send_item(right_ch ? rvm_pkg::MODE_LOAD_RIGHT : rvm_pkg::MODE_LOAD_LEFT, idx, word,
                  $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic set_position(input logic [31:0] pos);
        send_item(rvm_pkg::MODE_SET_POS, 8'($urandom), 16'($urandom), pos,
                  16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic mix_frame(input logic [15:0] smp, input logic [15:0] dl,
                             input logic [15:0] dr, input bit last);
        send_item(rvm_pkg::MODE_MIX, 8'($urandom), 16'($urandom), $urandom, smp, dl, dr, last);
    endtask

    task automatic random_item(input bit mix_only);
        int r;
        r = mix_only ? 99 : $urandom_range(99);
        if (r < 8)
            load_entry(1'b0, 8'($urandom), 16'($urandom));
        else if (r < 16)
            load_entry(1'b1, 8'($urandom), 16'($urandom));
        else if (r < 22)
            set_position($urandom);
        else
            mix_frame(16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(7) == 0);
    endtask

    // hold until the block has nothing left in flight
    task automatic wait_idle;
        while (expected_frames.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_idx)
            rvm_pkg::REG_FORMAT: cfg_format = rvm_pkg::t_fmt'(value[1:0]);
            rvm_pkg::REG_STEREO: cfg_stereo = value[0];
            default:             cfg_step   = value;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] expected_v,
                               input logic [31:0] actual_v);
        if (expected_v !== actual_v) begin
            $error("%s: expected %h, got %h", name, expected_v, actual_v);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_frames.size() == 0) begin
                $error("mixed frame with none outstanding");
                n_errors++;
            end else begin
                want = expected_frames.pop_front();
                check_field("mixed_left", want.left, o_mixed_left);
                check_field("mixed_right", want.right, o_mixed_right);
                check_field("next_source_index", want.index, o_next_source_index);
                check_field("position_out", want.position, o_position_out);
                check_field("call_done", want.done, o_call_done);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            i_ready = 1'b0;
            hold_left--;
        end else begin
            i_ready = steady || ($urandom_range(99) >= 11);
        end
    end

    task automatic fill_volume_tables;
        for (int i = 0; i < rvm_pkg::TABLE_ENTRIES; i++) begin
            load_entry(1'b0, 8'(i), 16'($urandom));
            load_entry(1'b1, 8'(i), 16'($urandom));
        end
    endtask

    task automatic test_directed_extremes;
        load_entry(1'b0, 8'h00, 16'h8080);
        load_entry(1'b0, 8'hFF, 16'h7F7F);
        load_entry(1'b0, 8'h80, 16'h8000);
        load_entry(1'b0, 8'h7F, 16'h7FFF);
        load_entry(1'b1, 8'h00, 16'h7F7F);
        load_entry(1'b1, 8'hFF, 16'h8080);
        load_entry(1'b1, 8'h80, 16'h7FFF);
        load_entry(1'b1, 8'h7F, 16'h8000);
        set_position(32'hFFFF_8000);
        wait_idle();
        write_reg(rvm_pkg::REG_STEREO, 32'd1);
        for (int f = 0; f < 4; f++) begin
            wait_idle();
            write_reg(rvm_pkg::REG_FORMAT, 32'(f));
            mix_frame(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
            mix_frame(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
            mix_frame(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
            mix_frame(16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        end
    endtask

    task automatic test_step_extremes;
        wait_idle();
        write_reg(rvm_pkg::REG_STEREO, 32'd0);
        write_reg(rvm_pkg::REG_STEP, 32'd0);
        set_position(32'hFFFF_FFFF);
        repeat (3) mix_frame(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        wait_idle();
        write_reg(rvm_pkg::REG_STEP, 32'hFFFF_FFFF);
        repeat (3) mix_frame(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        wait_idle();
        write_reg(rvm_pkg::REG_STEP, rvm_pkg::STEP_RESET);
    endtask

    task automatic test_random_mix;
        logic [31:0] step;
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case ($urandom_range(4))
                0:       step = 32'd0;
                1:       step = 32'hFFFF_FFFF;
                2:       step = rvm_pkg::STEP_RESET;
                3:       step = $urandom_range(32'h0004_0000);
                default: step = $urandom;
            endcase
            write_reg(rvm_pkg::REG_FORMAT, 32'(ph % 4));
            write_reg(rvm_pkg::REG_STEREO, 32'(ph / 4));
            write_reg(rvm_pkg::REG_STEP, step);
            steady = (ph == 5);
            repeat ((ph == 5) ? 100 : 20) random_item(1'b0);
            steady = 1'b0;
        end
    endtask

    task automatic test_backpressure;
        @(posedge i_clk);
        hold_req++;
        @(negedge i_clk);
        repeat (40) random_item(1'b1);
    endtask

    task automatic test_drain_pause;
        wait_idle();
        repeat (30) random_item(1'b0);
    endtask

    initial begin
        int waited;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        fill_volume_tables();
        test_directed_extremes();
        test_step_extremes();
        test_random_mix();
        test_backpressure();
        test_drain_pause();
        waited = 0;
        while (expected_frames.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_frames.size() != 0) begin
            $error("%0d mixed frames never arrived", expected_frames.size());
            n_errors++;
        end
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("** resampling_voice_mixer_core: PASSED **");
        end else begin
            $display("** resampling_voice_mixer_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** resampling_voice_mixer_core: FAILED **");
        $finish;
    end

endmodule
